// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("assertion failed");

`endif

// File: rtl/ffba_pkg.sv
// types and constants of the first-fit block allocator
package ffba_pkg;

   localparam int POOL_UNITS = 128;
   localparam int IDX_W      = $clog2(POOL_UNITS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int SIZE_W     = 8;
   localparam int ADDR_W     = 7;
   localparam int LEN_W      = 8;
   localparam int ADDR_LIMIT = 128;

   typedef enum logic {
      REQ_ALLOC   = 1'b0,
      REQ_RELEASE = 1'b1
   } req_kind_type;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // scan token handed from cell to cell
   typedef struct packed {
      logic               active;
      req_kind_type       op;
      logic [SIZE_W-1:0]  size;
      logic [ADDR_W-1:0]  addr;
      logic [CNT_W-1:0]   run;
      logic [LEN_W-1:0]   remaining;
      logic               done;
      logic               err;
      logic [IDX_W-1:0]   first;
      logic [IDX_W-1:0]   last;
   } token_type;

   // allocation commit broadcast to every cell
   typedef struct packed {
      logic               set;
      logic [IDX_W-1:0]   first;
      logic [IDX_W-1:0]   last;
      logic [LEN_W-1:0]   len;
   } commit_type;

endpackage

// File: rtl/ffba_req_if.sv
// request channel interface
interface ffba_req_if;
   import ffba_pkg::*;

   logic              valid;
   logic              ready;
   logic              req_type;
   logic [SIZE_W-1:0] block_size;
   logic [ADDR_W-1:0] block_addr;

   modport source (output valid, output req_type, output block_size, output block_addr,
                   input ready);
   modport sink   (input valid, input req_type, input block_size, input block_addr,
                   output ready);
endinterface

// File: rtl/ffba_rsp_if.sv
// response channel interface
interface ffba_rsp_if;
   import ffba_pkg::*;

   logic              valid;
   logic              ready;
   logic              status;
   logic [ADDR_W-1:0] granted_addr;

   modport source (output valid, output status, output granted_addr, input ready);
   modport sink   (input valid, input status, input granted_addr, output ready);
endinterface

// File: rtl/ffba_cell.sv
// one pool unit: busy bit, block length and a token stage
module ffba_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ffba_pkg::IDX_W-1:0]  cell_index,
   input  ffba_pkg::token_type         token_in,
   input  ffba_pkg::commit_type        commit,
   output ffba_pkg::token_type         token_out
);
   import ffba_pkg::*;

   logic             busy_ff, busy_in;
   logic [LEN_W-1:0] len_ff, len_in;
   token_type        tok_ff, tok_in;
   logic [CNT_W-1:0] run_next;
   logic [CNT_W-1:0] first_wide;
   logic             addr_hit;

   assign token_out = tok_ff;

   always_comb begin
      busy_in    = busy_ff;
      len_in     = len_ff;
      tok_in     = token_in;
      run_next   = token_in.run + CNT_W'(1);
      first_wide = CNT_W'(cell_index) + CNT_W'(1) - run_next;
      addr_hit   = (32'(cell_index) == 32'(token_in.addr));

      if (token_in.active && !token_in.done && token_in.op == REQ_ALLOC) begin
         if (busy_ff) begin
            tok_in.run = '0;
         end else begin
            tok_in.run = run_next;
            if (32'(run_next) == 32'(token_in.size)) begin
               tok_in.done  = 1'b1;
               tok_in.first = first_wide[IDX_W-1:0];
               tok_in.last  = cell_index;
               tok_in.err   = (32'(first_wide) >= ADDR_LIMIT);
            end
         end
      end

      if (token_in.active && token_in.op == REQ_RELEASE) begin
         if (!token_in.done) begin
            if (addr_hit) begin
               tok_in.done = 1'b1;
               if (len_ff == '0) begin
                  tok_in.err = 1'b1;
               end else begin
                  busy_in          = 1'b0;
                  len_in           = '0;
                  tok_in.remaining = len_ff - LEN_W'(1);
               end
            end
         end else if (!token_in.err && token_in.remaining != '0) begin
            // tail of the block being freed
            busy_in          = 1'b0;
            tok_in.remaining = token_in.remaining - LEN_W'(1);
         end
      end

      if (commit.set && cell_index >= commit.first && cell_index <= commit.last) begin
         busy_in = 1'b1;
      end
      if (commit.set && cell_index == commit.first) begin
         len_in = commit.len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= '0;
         busy_ff <= 1'b0;
         len_ff  <= '0;
      end else begin
         tok_ff  <= tok_in;
         busy_ff <= busy_in;
         len_ff  <= len_in;
      end
   end
endmodule

// File: rtl/ffba_chain.sv
// row of pool cells, token enters at unit 0 and leaves after the last unit
module ffba_chain (
   input  logic                  clock,
   input  logic                  reset,
   input  ffba_pkg::token_type   token_in,
   input  ffba_pkg::commit_type  commit,
   output ffba_pkg::token_type   token_out
);
   import ffba_pkg::*;

   token_type link [POOL_UNITS+1];

   assign link[0]   = token_in;
   assign token_out = link[POOL_UNITS];

   for (genvar i = 0; i < POOL_UNITS; i++) begin : g_cell
      ffba_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .token_in   (link[i]),
         .commit     (commit),
         .token_out  (link[i+1])
      );
   end
endmodule

// File: rtl/first_fit_block_allocator.sv
// top level of the first-fit block allocator
// Manages a pool of POOL_UNITS units (128) handed out first-fit. An allocate
// item (req_type 0) asks for block_size units and gets the lowest start address
// of a free run of that length; a release item (req_type 1) frees the whole
// block starting at block_addr. Every item gives one response item: status 0
// on success, 1 on error (size 0 or above the pool, no fit, or an address that
// is not a block start); granted_addr carries the start on allocate success
// and is 0 otherwise. One item is worked at a time. Once an item is accepted,
// the token is launched into a register, then it walks the row of unit cells
// one cell per cycle, then the result is registered and an allocation is
// written back to every cell in one broadcast; the response is loaded when
// the response register is free. The next item is taken once the response is
// loaded, even while the response still waits for rsp.ready. The pool is
// empty right after reset.
module first_fit_block_allocator (
   input  logic         clock,
   input  logic         reset,
   ffba_req_if.sink     req,
   ffba_rsp_if.source   rsp
);
   import ffba_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN
   } state_type;

   state_type         state_ff, state_in;
   token_type         launch_ff, launch_in;
   commit_type        commit_ff, commit_in;
   logic              res_status_ff, res_status_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   token_type         tail;
   logic              bad_size;
   logic              tail_alloc;
   logic              tail_err;

   // row of unit cells
   ffba_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .token_in  (launch_ff),
      .commit    (commit_ff),
      .token_out (tail)
   );

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.granted_addr = rsp_addr_ff;

   // zero size or larger than the pool fails without a fit search
   assign bad_size = (req.req_type == REQ_ALLOC) &&
                     (req.block_size == '0 || 32'(req.block_size) > POOL_UNITS);

   assign tail_alloc = (tail.op == REQ_ALLOC);
   // a token that passed every cell without finishing found nothing
   assign tail_err   = !tail.done || tail.err;

   always_comb begin
      state_in         = state_ff;
      launch_in        = launch_ff;
      launch_in.active = 1'b0;
      commit_in        = commit_ff;
      commit_in.set    = 1'b0;
      res_status_in    = res_status_ff;
      res_addr_in      = res_addr_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_addr_in      = rsp_addr_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               // launch a fresh token into unit 0
               launch_in.active    = 1'b1;
               launch_in.op        = req_kind_type'(req.req_type);
               launch_in.size      = req.block_size;
               launch_in.addr      = req.block_addr;
               launch_in.run       = '0;
               launch_in.remaining = '0;
               launch_in.done      = bad_size;
               launch_in.err       = bad_size;
               launch_in.first     = '0;
               launch_in.last      = '0;
               state_in            = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail.active) begin
               res_status_in   = tail_err ? STATUS_ERR : STATUS_OK;
               res_addr_in     = (tail_alloc && !tail_err) ? ADDR_W'(tail.first) : '0;
               // mark the granted run busy in every cell at once
               commit_in.set   = tail_alloc && !tail_err;
               commit_in.first = tail.first;
               commit_in.last  = tail.last;
               commit_in.len   = LEN_W'(tail.size);
               state_in        = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= '0;
         commit_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         commit_ff    <= commit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// File: rtl/ffba_checker.sv
// port-level checker of the allocator and its bind
`include "assert_macros.svh"

module ffba_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_status,
   input logic [ffba_pkg::ADDR_W-1:0] rsp_granted_addr
);
   import ffba_pkg::*;

   // a waiting response stays offered
   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)

   // a failed item never reports a start address
   `ASSERT_CLK(a_err_addr, rsp_valid && rsp_status == STATUS_ERR |-> rsp_granted_addr == '0)

   // one item at a time: an accepted item closes the request side
   `ASSERT_CLK(a_one_in_flight, req_valid && req_ready |=> !req_ready)

   // no response is offered right after reset
   `ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid)
endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_status       (rsp.status),
   .rsp_granted_addr (rsp.granted_addr)
);

// File: tb/tb_top.sv
// self-checking testbench of the first-fit block allocator
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ffba_pkg::*;

   // cycles with no item accepted on either side before the run is abandoned
   localparam int IDLE_LIMIT = 20000;
   // length of the one long response hold-off
   localparam int LONG_HOLD  = 1500;

   // one response item as the block should return it
   typedef struct {
      logic              status;
      logic [ADDR_W-1:0] addr;
   } grant_type;

   logic clock;
   logic reset;

   ffba_req_if req_bus ();
   ffba_rsp_if rsp_bus ();

   first_fit_block_allocator dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // shadow copy of the pool: which units are taken, and block lengths by start
   bit             pool_busy [POOL_UNITS];
   bit [LEN_W-1:0] pool_len  [POOL_UNITS];

   // responses still owed by the block, oldest first
   grant_type grant_queue [$];

   int fail_count   = 0;
   int results_seen = 0;
   int items_sent   = 0;
   int grants_ok    = 0;
   int frees_ok     = 0;
   int refusals     = 0;

   // response number at which the receiver starts the long hold-off
   int hold_after   = -1;
   bit long_hold_hit = 1'b0;

   // sender pacing: bursts of random length, random gaps between them
   bit pacing     = 1'b1;
   int burst_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // first-fit search and release on the shadow pool, returns the response
   function automatic grant_type apply_pool_request(req_kind_type kind,
                                                    logic [SIZE_W-1:0] size,
                                                    logic [ADDR_W-1:0] addr);
      grant_type g;
      int        run;
      int        first;
      int        a;
      g.status = STATUS_ERR;
      g.addr   = '0;
      run      = 0;
      first    = -1;
      if (kind == REQ_ALLOC) begin
         // zero size and anything above the pool are refused outright
         if (size != 0 && size <= POOL_UNITS) begin
            for (int i = 0; i < POOL_UNITS && first < 0; i++) begin
               if (pool_busy[i]) begin
                  run = 0;
               end else begin
                  run++;
                  if (run == int'(size)) first = i + 1 - run;
               end
            end
            // a start that does not fit the address field counts as no fit
            if (first >= 0 && first < ADDR_LIMIT) begin
               for (int i = first; i < first + run; i++) pool_busy[i] = 1'b1;
               pool_len[first] = LEN_W'(run);
               g.status = STATUS_OK;
               g.addr   = ADDR_W'(first);
            end
         end
      end else begin
         // only the start of a live block can be freed
         a = int'(addr);
         if (a < POOL_UNITS && pool_len[a] != 0) begin
            for (int i = a; i < a + int'(pool_len[a]) && i < POOL_UNITS; i++)
               pool_busy[i] = 1'b0;
            pool_len[a] = '0;
            g.status = STATUS_OK;
         end
      end
      if (g.status == STATUS_ERR) refusals++;
      else if (kind == REQ_ALLOC) grants_ok++;
      else frees_ok++;
      return g;
   endfunction

   // a random live block start, or -1 when the pool is empty
   function automatic int pick_live_start();
      int base;
      base = $urandom_range(0, POOL_UNITS - 1);
      for (int k = 0; k < POOL_UNITS; k++) begin
         if (pool_len[(base + k) % POOL_UNITS] != 0) return (base + k) % POOL_UNITS;
      end
      return -1;
   endfunction

   // offer one item, wait for it to be taken, record the owed response
   task automatic send_item(req_kind_type kind, logic [SIZE_W-1:0] size,
                            logic [ADDR_W-1:0] addr);
      int gap;
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.block_size <= size;
      req_bus.block_addr <= addr;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      grant_queue.push_back(apply_pool_request(kind, size, addr));
      items_sent++;
      if (pacing) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
            // valid drops only when a real gap follows
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   endtask

   // release every live block, unused size field random
   task automatic free_all_blocks();
      for (int i = 0; i < POOL_UNITS; i++) begin
         if (pool_len[i] != 0)
            send_item(REQ_RELEASE, SIZE_W'($urandom_range(0, 255)), ADDR_W'(i));
      end
   endtask

   // mostly well-formed traffic: small allocations and frees of live blocks,
   // with some bad addresses, bad sizes and large requests mixed in
   task automatic send_random_item();
      int               r;
      int               start;
      logic [SIZE_W-1:0] sz;
      r  = $urandom_range(0, 99);
      sz = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(17, POOL_UNITS))
                                       : SIZE_W'($urandom_range(1, 16));
      start = pick_live_start();
      if (r < 45 || (r < 85 && start < 0)) begin
         send_item(REQ_ALLOC, sz, ADDR_W'($urandom_range(0, 127)));
      end else if (r < 85) begin
         send_item(REQ_RELEASE, SIZE_W'($urandom_range(0, 255)), ADDR_W'(start));
      end else if (r < 92) begin
         // free at a random address, usually not a block start
         send_item(REQ_RELEASE, SIZE_W'($urandom_range(0, 255)),
                   ADDR_W'($urandom_range(0, 127)));
      end else if (r < 96) begin
         // zero or oversize request
         sz = ($urandom_range(0, 1) == 0) ? '0 : SIZE_W'($urandom_range(POOL_UNITS + 1, 255));
         send_item(REQ_ALLOC, sz, ADDR_W'($urandom_range(0, 127)));
      end else begin
         // large request that often finds no run
         send_item(REQ_ALLOC, SIZE_W'($urandom_range(64, POOL_UNITS)),
                   ADDR_W'($urandom_range(0, 127)));
      end
   endtask

   // size edges, full pool, no fit, freeing inside a block and double free
   task automatic test_size_limits();
      send_item(REQ_ALLOC,   SIZE_W'(0),          ADDR_W'(0));   // zero size
      send_item(REQ_ALLOC,   SIZE_W'(POOL_UNITS + 1), ADDR_W'(0)); // one past the pool
      send_item(REQ_ALLOC,   SIZE_W'(255),        ADDR_W'(127)); // all size bits set
      send_item(REQ_ALLOC,   SIZE_W'(POOL_UNITS), ADDR_W'(127)); // whole pool, addr ignored
      send_item(REQ_ALLOC,   SIZE_W'(1),          ADDR_W'(0));   // pool full, no fit
      send_item(REQ_RELEASE, SIZE_W'(0),          ADDR_W'(1));   // inside block, not its start
      send_item(REQ_RELEASE, SIZE_W'(255),        ADDR_W'(0));   // size ignored on release
      send_item(REQ_RELEASE, SIZE_W'(5),          ADDR_W'(0));   // double free
   endtask

   // lowest fitting start wins, holes too small are skipped, top unit reachable
   task automatic test_first_fit_order();
      send_item(REQ_ALLOC, SIZE_W'(1), ADDR_W'(127));
      send_item(REQ_ALLOC, SIZE_W'(2), ADDR_W'(0));
      send_item(REQ_ALLOC, SIZE_W'(3), ADDR_W'(55));
      send_item(REQ_ALLOC, SIZE_W'(4), ADDR_W'(42));
      send_item(REQ_RELEASE, SIZE_W'(0), ADDR_W'(1));      // opens a two-unit hole
      send_item(REQ_ALLOC, SIZE_W'(3), ADDR_W'(0));        // too big for the hole
      send_item(REQ_ALLOC, SIZE_W'(2), ADDR_W'(0));        // fills the hole
      free_all_blocks();
      send_item(REQ_ALLOC, SIZE_W'(POOL_UNITS - 1), ADDR_W'(0));
      send_item(REQ_ALLOC, SIZE_W'(1), ADDR_W'(0));        // lands on the last unit
      send_item(REQ_ALLOC, SIZE_W'(1), ADDR_W'(0));        // nothing left
      send_item(REQ_RELEASE, SIZE_W'(1), ADDR_W'(127));
      send_item(REQ_RELEASE, SIZE_W'(1), ADDR_W'(127));    // already free
      free_all_blocks();
   endtask

   // long random run, pool drained now and then so it does not stay full
   task automatic test_random_traffic(int count);
      for (int n = 0; n < count; n++) begin
         if (n % 300 == 299) free_all_blocks();
         else send_random_item();
      end
   endtask

   // receiver holds off for a long stretch while items keep coming back to back
   task automatic test_response_backpressure();
      hold_after = results_seen + grant_queue.size() + 1;
      pacing     = 1'b0;
      repeat (20) send_random_item();
      pacing     = 1'b1;
   endtask

   // receiver: ready pattern of its own, checks every response taken
   initial begin : response_side
      grant_type want;
      int        hold_left;
      int        rx_cycle;
      hold_left = 0;
      rx_cycle  = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            results_seen++;
            if (grant_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("response %0d arrived with none pending: status %0b addr %0d",
                           results_seen, rsp_bus.status, rsp_bus.granted_addr);
            end else begin
               want = grant_queue.pop_front();
               if (rsp_bus.status !== want.status || rsp_bus.granted_addr !== want.addr) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("response %0d: expected status %0b addr %0d, got %0b addr %0d",
                              results_seen, want.status, want.addr,
                              rsp_bus.status, rsp_bus.granted_addr);
               end
            end
            // the long hold-off starts right after this response
            if (results_seen == hold_after) begin
               hold_left     = LONG_HOLD;
               long_hold_hit = 1'b1;
            end
         end
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case ((rx_cycle / 700) % 4)
               0: begin
                  rsp_bus.ready <= 1'b1;
               end
               1: begin
                  rsp_bus.ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_bus.ready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  // mostly ready, with an occasional stall of random length
                  if ($urandom_range(0, 99) == 0) hold_left = $urandom_range(20, 250);
                  rsp_bus.ready <= (hold_left == 0);
               end
            endcase
         end
      end
   end

   // watchdog: too long with nothing taken on either side ends the run
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            idle = 0;
         else
            idle++;
      end
      $display("no item moved for %0d cycles, %0d responses pending",
               IDLE_LIMIT, grant_queue.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_ALLOC;
      req_bus.block_size <= '0;
      req_bus.block_addr <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_size_limits();
      test_first_fit_order();
      test_random_traffic(1000);
      test_response_backpressure();
      req_bus.valid <= 1'b0;

      // drain, then give the block one more item time to show a stray response
      while (grant_queue.size() != 0) @(posedge clock);
      repeat (POOL_UNITS + 10) @(posedge clock);

      $display("%0d items: %0d blocks granted, %0d blocks freed, %0d refused",
               items_sent, grants_ok, frees_ok, refusals);
      $display("size edges, first-fit holes, double frees, long response stall seen: %0b",
               long_hold_hit);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches in total", fail_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
